// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the point-in-polygon rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define PIP_ASSERT_SAME(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition holds at the clock edge after the trigger
`define PIP_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/pip_pkg.sv =====
// shared constants, types and helpers of the point-in-polygon ray cast block
`default_nettype none

package pip_pkg;

	localparam int MAX_VERTICES = 6;
	localparam int COORD_BITS   = 12;
	localparam int RAY_FAR_X    = 10000;
	localparam int MIN_VERTICES = 3;
	localparam int VERTEX_REGS  = 6;

	localparam int VTX_W      = 2 * COORD_BITS;
	localparam int CNT_W      = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = (VTX_W > CNT_W) ? VTX_W : CNT_W;

	// signed widths of coordinate differences, cross products and their difference
	localparam int FAR_W  = $clog2(RAY_FAR_X + 1) + 1;
	localparam int DIFF_W = (COORD_BITS + 1 > FAR_W) ? COORD_BITS + 1 : FAR_W;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int SUM_W  = PROD_W + 1;

	localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_VERTEX_A     = CFG_IDX_W'(1);

	typedef logic [COORD_BITS-1:0]    coord_t;
	typedef logic signed [DIFF_W-1:0] diff_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0]  sum_t;

	typedef enum logic [1:0] {
		TURN_COL,
		TURN_POS,
		TURN_NEG
	} turn_t;

	// query point travelling down the edge chain with its running verdict
	typedef struct packed {
		coord_t px;
		coord_t py;
		logic   done;
		logic   res;
		logic   par;
	} tok_t;

	localparam diff_t FAR_S = diff_t'(RAY_FAR_X);

	function automatic diff_t widen(input coord_t c);
		return diff_t'(c);
	endfunction

	function automatic turn_t turn_of(input sum_t v);
		turn_t t;
		if (v == '0) begin
			t = TURN_COL;
		end else if (!v[SUM_W-1]) begin
			t = TURN_POS;
		end else begin
			t = TURN_NEG;
		end
		return t;
	endfunction

	// q inside the bounding box of segment a-b
	function automatic logic in_box(input diff_t ax, input diff_t ay, input diff_t qx,
			input diff_t qy, input diff_t bx, input diff_t by);
		return (qx <= ax || qx <= bx) && (qx >= ax || qx >= bx) &&
			(qy <= ay || qy <= by) && (qy >= ay || qy >= by);
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/point_in_polygon_ray_cast_top.sv =====
// top level: configuration registers, chain of edge cells and output register
`default_nettype none
`include "assert_macros.svh"

// Point-in-polygon test by horizontal ray casting. Each query point passes
// down a chain of MAX_VERTICES edge cells, one per polygon edge, each cell two
// pipeline stages deep (cross products, then orientation and verdict). The
// block takes one point per cycle while the output is not stalled and returns
// inside_res from the output register behind the last cell; a stalled output
// holds full stages in place while empty stages still take data.
// Write vertex_count and the vertex registers only while no point is in flight.

module point_in_polygon_ray_cast_top import pip_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [COORD_BITS-1:0] point_x,
	input  logic [COORD_BITS-1:0] point_y,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  inside_res
);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] n_eff;
	logic             too_few;

	tok_t             tok [MAX_VERTICES+1];
	logic             vld [MAX_VERTICES+1];
	logic             rdy [MAX_VERTICES+1];
	logic [VTX_W-1:0] vtx [MAX_VERTICES];

	logic out_valid_q, inside_q, out_ld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_we && cfg_index == REG_VERTEX_COUNT) begin
			count_q <= cfg_data[CNT_W-1:0];
		end
	end

	assign n_eff   = (count_q > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : count_q;
	assign too_few = n_eff < CNT_W'(MIN_VERTICES);

	// fewer than three vertices settles the answer before the first edge
	assign tok[0]   = '{px: point_x, py: point_y, done: too_few, res: 1'b0, par: 1'b0};
	assign vld[0]   = in_valid;
	assign in_stall = !rdy[0];

	for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
		logic             sel;
		logic [VTX_W-1:0] nxt;

		assign sel = cfg_we && (i < VERTEX_REGS) &&
			(cfg_index == CFG_IDX_W'(int'(REG_VERTEX_A) + i));
		// the last edge in use wraps back to vertex 0
		assign nxt = (n_eff == CNT_W'(i + 1)) ? vtx[0] : vtx[(i + 1) % MAX_VERTICES];

		pip_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cfg_sel   (sel),
			.cfg_data  (cfg_data[VTX_W-1:0]),
			.vtx       (vtx[i]),
			.vtx_next  (nxt),
			.act       (CNT_W'(i) < n_eff),
			.in_valid  (vld[i]),
			.in_ready  (rdy[i]),
			.in_tok    (tok[i]),
			.out_valid (vld[i+1]),
			.out_ready (rdy[i+1]),
			.out_tok   (tok[i+1])
		);
	end

	assign out_ld             = !out_valid_q || !out_stall;
	assign rdy[MAX_VERTICES]  = out_ld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ld) begin
			out_valid_q <= vld[MAX_VERTICES];
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			inside_q <= tok[MAX_VERTICES].done ? tok[MAX_VERTICES].res : tok[MAX_VERTICES].par;
		end
	end

	assign out_valid  = out_valid_q;
	assign inside_res = inside_q;

	`PIP_ASSERT_SAME(a_stall_source, in_stall, out_valid_q && out_stall,
		"input stalled while the output register can move")
	`PIP_ASSERT_NEXT(a_count_clamp, cfg_we && cfg_index == REG_VERTEX_COUNT,
		n_eff <= CNT_W'(MAX_VERTICES), "vertex count not clamped")

endmodule

`default_nettype wire

// ===== hw/rtl/pip_cell.sv =====
// one edge cell: holds a vertex, tests its edge against the ray in two stages
`default_nettype none
`include "assert_macros.svh"

module pip_cell import pip_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_sel,
	input  logic [VTX_W-1:0] cfg_data,
	output logic [VTX_W-1:0] vtx,
	input  logic [VTX_W-1:0] vtx_next,
	input  logic             act,
	input  logic             in_valid,
	output logic             in_ready,
	input  tok_t             in_tok,
	output logic             out_valid,
	input  logic             out_ready,
	output tok_t             out_tok
);

	logic [VTX_W-1:0] vtx_q;

	logic  valid_s1, valid_s2;
	tok_t  tok_s1, tok_s2;
	logic  act_s1;
	prod_t p_dyq_s1, p_dxb_s1, p_far_s1, p_c1_s1, p_c2_s1;
	logic  ay_gt_s1, ay_lt_s1, by_gt_s1, by_lt_s1;
	logic  box_apb_s1, box_adb_s1, box_pad_s1, box_pbd_s1;

	logic  ld1, ld2;
	diff_t ax, ay, bx, by, qx, qy;
	diff_t dy_ab, dx_ab;
	sum_t  v1, v2, v3;
	turn_t o1, o2, o3, o4;
	logic  meet;
	tok_t  nxt_tok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vtx_q <= '0;
		end else if (cfg_sel) begin
			vtx_q <= cfg_data;
		end
	end

	assign vtx = vtx_q;

	assign ld2      = !valid_s2 || out_ready;
	assign ld1      = !valid_s1 || ld2;
	assign in_ready = ld1;

	assign ax    = widen(vtx_q[COORD_BITS-1:0]);
	assign ay    = widen(vtx_q[VTX_W-1:COORD_BITS]);
	assign bx    = widen(vtx_next[COORD_BITS-1:0]);
	assign by    = widen(vtx_next[VTX_W-1:COORD_BITS]);
	assign qx    = widen(in_tok.px);
	assign qy    = widen(in_tok.py);
	assign dy_ab = by - ay;
	assign dx_ab = bx - ax;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ld1) begin
				valid_s1 <= in_valid;
			end
			if (ld2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// stage 1: cross products of the edge with the point and the far end, height compares and box tests
	always_ff @(posedge clk) begin
		if (ld1) begin
			tok_s1     <= in_tok;
			act_s1     <= act;
			p_dyq_s1   <= dy_ab * (qx - bx);
			p_dxb_s1   <= dx_ab * (qy - by);
			p_far_s1   <= dy_ab * (FAR_S - bx);
			p_c1_s1    <= (qy - ay) * (bx - qx);
			p_c2_s1    <= (qx - ax) * (by - qy);
			ay_gt_s1   <= ay > qy;
			ay_lt_s1   <= ay < qy;
			by_gt_s1   <= by > qy;
			by_lt_s1   <= by < qy;
			box_apb_s1 <= in_box(ax, ay, qx, qy, bx, by);
			box_adb_s1 <= in_box(ax, ay, FAR_S, qy, bx, by);
			box_pad_s1 <= in_box(qx, qy, ax, ay, FAR_S, qy);
			box_pbd_s1 <= in_box(qx, qy, bx, by, FAR_S, qy);
		end
	end

	// stage 2: orientation signs, intersection and verdict update
	assign v1 = sum_t'(p_dyq_s1) - sum_t'(p_dxb_s1);
	assign v2 = sum_t'(p_far_s1) - sum_t'(p_dxb_s1);
	assign v3 = sum_t'(p_c1_s1) - sum_t'(p_c2_s1);

	always_comb begin
		o1 = turn_of(v1);
		o2 = turn_of(v2);
		// the ray is horizontal, so its own turns only need the vertex height
		o3 = ay_gt_s1 ? TURN_NEG : (ay_lt_s1 ? TURN_POS : TURN_COL);
		o4 = by_gt_s1 ? TURN_NEG : (by_lt_s1 ? TURN_POS : TURN_COL);
		meet = (o1 != o2 && o3 != o4) ||
			(o1 == TURN_COL && box_apb_s1) ||
			(o2 == TURN_COL && box_adb_s1) ||
			(o3 == TURN_COL && box_pad_s1) ||
			(o4 == TURN_COL && box_pbd_s1);
		nxt_tok = tok_s1;
		if (act_s1 && !tok_s1.done && meet) begin
			if (v3 == '0) begin
				nxt_tok.done = 1'b1;
				nxt_tok.res  = box_apb_s1;
			end else begin
				nxt_tok.par = !tok_s1.par;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld2) begin
			tok_s2 <= nxt_tok;
		end
	end

	assign out_valid = valid_s2;
	assign out_tok   = tok_s2;

	`PIP_ASSERT_NEXT(a_done_kept, ld2 && valid_s1 && tok_s1.done,
		tok_s2.done && tok_s2.res == $past(tok_s1.res), "settled verdict changed in cell")
	`PIP_ASSERT_NEXT(a_idle_cell, ld2 && valid_s1 && !act_s1,
		tok_s2.par == $past(tok_s1.par) && tok_s2.done == $past(tok_s1.done),
		"unused edge cell altered the token")

endmodule

`default_nettype wire
